/* hw/rtl/gqbp_pkg.sv */
// Package with constants, types and helpers for the gray quantize bit packer.
package gqbp_pkg;

    localparam int unsigned PIX_W      = 8;
    localparam int unsigned PROD_W     = 2 * PIX_W;
    localparam int unsigned POS_W      = 3;
    localparam int unsigned CW_W       = 4;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [PIX_W-1:0] MAX_LEVEL_RESET = 8'd255;

    typedef struct packed {
        logic [PIX_W-1:0] data;
        logic             eoi;
    } t_beat;

    // Bit length of the maximum level, which is the code width.
    function automatic logic [CW_W-1:0] code_width(input logic [PIX_W-1:0] level);
        logic [CW_W-1:0] w;
        w = '0;
        for (int i = 0; i < PIX_W; i++) begin
            if (level[i]) begin
                w = CW_W'(i + 1);
            end
        end
        return w;
    endfunction

    // Exact floor(x / 255) for a product of two 8-bit values.
    function automatic logic [PIX_W-1:0] div_full_scale(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] s;
        s = {1'b0, x} + (PROD_W+1)'(x[PROD_W-1:PIX_W]) + (PROD_W+1)'(1);
        return s[PROD_W-1:PIX_W];
    endfunction

endpackage

/* hw/rtl/gray_quantize_bit_packer_core.sv */
// Top level of the gray quantize bit packer: input register, packer and output queue.
//
//  Channel  | Valid          | Ready        | Payload
//  ---------+----------------+--------------+---------------------------------
//  pixel in | i_in_valid     | o_in_ready   | i_pixel, i_is_last
//  bytes out| o_out_valid    | i_out_ready  | o_packed_byte, o_end_of_image
//  config   | i_cfg_valid    | o_cfg_ready  | i_cfg_max_level
//
// A pixel beat is registered, then quantized and packed combinationally into a
// four-entry output queue; one pixel per cycle is taken while the queue has room
// for two result beats. A pixel that yields two bytes holds the input back once
// the queue fills, since the output drains one beat per cycle while i_out_ready
// is high. Reset empties the queue, clears the accumulator and sets the maximum
// level to 255. Configuration is always ready.
module gray_quantize_bit_packer_core
    import gqbp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic             i_is_last,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [PIX_W-1:0] o_packed_byte,
    output logic             o_end_of_image,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [PIX_W-1:0] i_cfg_max_level
);

    logic [PIX_W-1:0] r_max_level;
    logic             r_in_valid;
    logic [PIX_W-1:0] r_in_pixel;
    logic             r_in_last;
    logic [PIX_W-1:0] r_acc;
    logic [POS_W-1:0] r_pos;
    t_beat            r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    logic [PIX_W-1:0]  n_acc;
    logic [POS_W-1:0]  n_pos;
    logic [CNT_W-1:0]  n_count;

    logic              pop;
    logic              consume;
    logic [CNT_W:0]    space;
    logic [PIX_W-1:0]  code;
    logic [CW_W-1:0]   width;
    logic [CW_W:0]     total;
    logic [CW_W:0]     shamt;
    logic [PROD_W-1:0] window;
    logic              full;
    logic [PIX_W-1:0]  acc_after;
    logic              push_full;
    logic              push_flush;
    t_beat             beat_full;
    t_beat             beat_flush;

    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = (r_count != '0);
    assign o_packed_byte  = r_fifo[r_rptr].data;
    assign o_end_of_image = r_fifo[r_rptr].eoi;

    assign pop     = o_out_valid && i_out_ready;
    assign space   = (CNT_W+1)'(FIFO_DEPTH) - (CNT_W+1)'(r_count) + (CNT_W+1)'(pop);
    assign consume = r_in_valid && (space >= (CNT_W+1)'(2));
    assign o_in_ready = !r_in_valid || consume;

    always_comb begin
        code   = div_full_scale(PROD_W'(r_in_pixel) * PROD_W'(r_max_level));
        width  = code_width(r_max_level);
        total  = (CW_W+1)'(r_pos) + (CW_W+1)'(width);
        shamt  = (CW_W+1)'(PROD_W) - total;
        window = {r_acc, PIX_W'(0)} | (PROD_W'(code) << shamt);
        full   = (total >= (CW_W+1)'(PIX_W));
        if (full) begin
            acc_after = window[PIX_W-1:0];
            n_pos     = POS_W'(total - (CW_W+1)'(PIX_W));
        end else begin
            acc_after = window[PROD_W-1:PIX_W];
            n_pos     = POS_W'(total);
        end
        n_acc           = acc_after;
        beat_full.data  = window[PROD_W-1:PIX_W];
        beat_full.eoi   = 1'b0;
        beat_flush.data = acc_after;
        beat_flush.eoi  = 1'b1;
        if (r_in_last) begin
            n_acc = '0;
            n_pos = '0;
        end
        push_full  = consume && full;
        push_flush = consume && r_in_last;
        n_count    = r_count + CNT_W'(push_full) + CNT_W'(push_flush) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_level <= MAX_LEVEL_RESET;
            r_in_valid  <= 1'b0;
            r_acc       <= '0;
            r_pos       <= '0;
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_count     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_max_level <= i_cfg_max_level;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (consume) begin
                r_acc <= n_acc;
                r_pos <= n_pos;
            end
            r_wptr  <= r_wptr + PTR_W'(push_full) + PTR_W'(push_flush);
            if (pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_pixel <= i_pixel;
            r_in_last  <= i_is_last;
        end
        if (push_full) begin
            r_fifo[r_wptr] <= beat_full;
        end
        if (push_flush) begin
            r_fifo[r_wptr + PTR_W'(push_full)] <= beat_flush;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("output queue count exceeds its depth");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && r_in_last |=> (r_pos == '0) && (r_acc == '0))
        else $error("accumulator not cleared after the last pixel");

    a_held_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !consume |=> r_in_valid && $stable(r_in_pixel) && $stable(r_in_last))
        else $error("registered pixel lost while waiting for queue space");
`endif

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the gray quantize bit packer core.
module tb_top;
    import gqbp_pkg::*;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 220;
    localparam int DIR_ROWS    = 24;
    localparam int LIMIT       = 200000;
    localparam int SETTLE      = 8;
    localparam bit CFG         = 1'b1;
    localparam bit PIX         = 1'b0;
    localparam bit TYPED       = 1'b1;
    localparam bit PRED        = 1'b0;
    localparam t_beat NO_BEAT  = '{8'h00, 1'b0};

    typedef struct packed {
        logic       is_cfg;
        logic [7:0] value;
        logic       last;
        logic       typed;
        logic [1:0] n_typed;
        t_beat      t0;
        t_beat      t1;
    } t_dir_row;

    typedef struct packed {
        logic [7:0] pixel;
        logic       last;
        logic       typed;
        logic [1:0] n_typed;
        t_beat      t0;
        t_beat      t1;
    } t_pix_item;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [PIX_W-1:0] i_pixel = '0;
    logic             i_is_last = 1'b0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [PIX_W-1:0] o_packed_byte;
    logic             o_end_of_image;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [PIX_W-1:0] i_cfg_max_level = '0;

    logic [7:0] level = MAX_LEVEL_RESET;
    logic [7:0] acc_byte = '0;
    logic [2:0] acc_bits = '0;
    t_beat      exp_bytes [$];
    t_pix_item  pixel_q [$];
    t_pix_item  cur_item;
    t_dir_row   dir_table [DIR_ROWS];
    logic       in_fire = 1'b0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    int         errors = 0;
    int         cycles = 0;

    gray_quantize_bit_packer_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pixel        (i_pixel),
        .i_is_last      (i_is_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_packed_byte  (o_packed_byte),
        .o_end_of_image (o_end_of_image),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_max_level(i_cfg_max_level)
    );

    always #10 i_clk = ~i_clk;

    task automatic pack_pixel(input logic [7:0] px, input logic lst);
        logic [15:0] prod;
        logic [7:0]  code;
        int          width;
        prod = 16'(px) * 16'(level);
        code = 8'(prod / 16'd255);
        width = 0;
        for (int b = 0; b < 8; b++) begin
            if (level[b]) begin
                width = b + 1;
            end
        end
        for (int j = width - 1; j >= 0; j--) begin
            acc_byte = acc_byte | (8'(code[j]) << (7 - acc_bits));
            if (acc_bits == 3'd7) begin
                exp_bytes.push_back(t_beat'{acc_byte, 1'b0});
                acc_byte = '0;
                acc_bits = '0;
            end else begin
                acc_bits = acc_bits + 3'd1;
            end
        end
        if (lst) begin
            exp_bytes.push_back(t_beat'{acc_byte, 1'b1});
            acc_byte = '0;
            acc_bits = '0;
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pixel_q.size() != 0 || i_in_valid || exp_bytes.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_level(input logic [7:0] lvl);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_max_level <= lvl;
        do @(negedge i_clk);
        while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        level = lvl;
    endtask

    always @(posedge i_clk) begin
        int n_before;
        if (i_rst_n) begin
            if (in_fire) begin
                n_before = exp_bytes.size();
                pack_pixel(cur_item.pixel, cur_item.last);
                if (cur_item.typed) begin
                    while (exp_bytes.size() > n_before) begin
                        void'(exp_bytes.pop_back());
                    end
                    exp_bytes.push_back(cur_item.t0);
                    if (cur_item.n_typed == 2'd2) begin
                        exp_bytes.push_back(cur_item.t1);
                    end
                end
            end
            if (!i_in_valid || in_fire) begin
                if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_item = pixel_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_pixel <= cur_item.pixel;
                    i_is_last <= cur_item.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(negedge i_clk) begin
        t_beat want;
        in_fire = i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_bytes.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual byte %02h eoi %0b",
                         $time, o_packed_byte, o_end_of_image);
                errors++;
            end else begin
                want = exp_bytes.pop_front();
                if (o_packed_byte !== want.data) begin
                    $display("%0t: packed_byte mismatch, expected %02h, actual %02h",
                             $time, want.data, o_packed_byte);
                    errors++;
                end
                if (o_end_of_image !== want.eoi) begin
                    $display("%0t: end_of_image mismatch, expected %0b, actual %0b",
                             $time, want.eoi, o_end_of_image);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_pix_item  item;
        logic [7:0] lvl;
        dir_table = '{
            '{PIX, 8'h00, 1'b0, TYPED, 2'd1, '{8'h00, 1'b0}, NO_BEAT},
            '{PIX, 8'hFF, 1'b0, TYPED, 2'd1, '{8'hFF, 1'b0}, NO_BEAT},
            '{PIX, 8'hA5, 1'b1, TYPED, 2'd2, '{8'hA5, 1'b0}, '{8'h00, 1'b1}},
            '{PIX, 8'h5A, 1'b0, TYPED, 2'd1, '{8'h5A, 1'b0}, NO_BEAT},
            '{PIX, 8'h00, 1'b1, TYPED, 2'd2, '{8'h00, 1'b0}, '{8'h00, 1'b1}},
            '{CFG, 8'd1,  1'b0, PRED,  2'd0, NO_BEAT, NO_BEAT},
            '{PIX, 8'hFF, 1'b1, TYPED, 2'd1, '{8'h80, 1'b1}, NO_BEAT},
            '{PIX, 8'hFE, 1'b1, TYPED, 2'd1, '{8'h00, 1'b1}, NO_BEAT},
            '{PIX, 8'h00, 1'b1, TYPED, 2'd1, '{8'h00, 1'b1}, NO_BEAT},
            '{PIX, 8'hFF, 1'b0, PRED,  2'd0, NO_BEAT, NO_BEAT},
            '{PIX, 8'hFF, 1'b0, PRED,  2'd0, NO_BEAT, NO_BEAT},
            '{PIX, 8'hFF, 1'b0, PRED,  2'd0, NO_BEAT, NO_BEAT},
            '{PIX, 8'hFF, 1'b0, PRED,  2'd0, NO_BEAT, NO_BEAT},
            '{PIX, 8'hFF, 1'b0, PRED,  2'd0, NO_BEAT, NO_BEAT},
            '{PIX, 8'hFF, 1'b0, PRED,  2'd0, NO_BEAT, NO_BEAT},
            '{PIX, 8'hFF, 1'b0, PRED,  2'd0, NO_BEAT, NO_BEAT},
            '{PIX, 8'hFF, 1'b1, PRED,  2'd0, NO_BEAT, NO_BEAT},
            '{CFG, 8'd7,  1'b0, PRED,  2'd0, NO_BEAT, NO_BEAT},
            '{PIX, 8'h80, 1'b0, PRED,  2'd0, NO_BEAT, NO_BEAT},
            '{PIX, 8'hFF, 1'b0, PRED,  2'd0, NO_BEAT, NO_BEAT},
            '{PIX, 8'h40, 1'b1, PRED,  2'd0, NO_BEAT, NO_BEAT},
            '{CFG, 8'd128, 1'b0, PRED, 2'd0, NO_BEAT, NO_BEAT},
            '{PIX, 8'hFF, 1'b1, PRED,  2'd0, NO_BEAT, NO_BEAT},
            '{CFG, 8'd255, 1'b0, PRED, 2'd0, NO_BEAT, NO_BEAT}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_table[r].is_cfg) begin
                write_level(dir_table[r].value);
            end else begin
                item = '{dir_table[r].value, dir_table[r].last, dir_table[r].typed,
                         dir_table[r].n_typed, dir_table[r].t0, dir_table[r].t1};
                pixel_q.push_back(item);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: lvl = 8'd1;
                1: lvl = 8'd255;
                2: lvl = 8'd2;
                3: lvl = 8'd128;
                6: lvl = 8'd127;
                default: lvl = 8'($urandom_range(255, 1));
            endcase
            write_level(lvl);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 59; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 59; end
                default: begin send_idle_pct = 19; stall_pct = 19; end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                case ($urandom_range(7))
                    0: item.pixel = 8'h00;
                    1: item.pixel = 8'hFF;
                    default: item.pixel = 8'($urandom_range(255));
                endcase
                item.last = ($urandom_range(15) == 0);
                item.typed = PRED;
                item.n_typed = 2'd0;
                item.t0 = NO_BEAT;
                item.t1 = NO_BEAT;
                pixel_q.push_back(item);
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

/* sim.f */
hw/rtl/gqbp_pkg.sv
hw/rtl/gray_quantize_bit_packer_core.sv
dv/tb_top.sv
